>>> rtl/vufp_pkg.sv
package vufp_pkg;

   localparam int unsigned HDR_LEN = 10;
   localparam int unsigned HDR_CNT_BITS = 4;

   localparam logic [7:0] MARK_LAST = 8'hFF;
   localparam logic [7:0] MARK_MORE = 8'h00;

   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_MARK  = 4'd0;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_INDEX = 4'd1;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_SEQ0  = 4'd2;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_SEQ1  = 4'd3;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_SEQ2  = 4'd4;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_SEQ3  = 4'd5;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_FMT0  = 4'd6;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_FMT1  = 4'd7;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_FMT2  = 4'd8;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_FMT3  = 4'd9;
   localparam logic [HDR_CNT_BITS-1:0] HDR_POS_DONE  = HDR_CNT_BITS'(HDR_LEN);

   localparam logic CSR_MAX_PAYLOAD   = 1'b0;
   localparam logic CSR_STREAM_FORMAT = 1'b1;

   localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd50000;
   localparam logic [31:0] STREAM_FORMAT_RESET = 32'd19;

   typedef struct packed {
      logic [7:0] data;
      logic       open;
      logic       mark_last;
      logic       packet_last;
      logic       unit_last;
   } job_type;

endpackage

>>> rtl/video_unit_fragment_packetizer.sv
// video unit fragment packetizer
// req channel: one byte of a video unit per beat, with the unit length and a
// first-byte flag; the length is taken on the first byte only.
// rsp channel: wire bytes; a byte that opens a packet is preceded by a 10-byte
// header (marker, packet index, unit sequence number, stream format word).
// csr port: index 0 writes max_payload, index 1 writes stream_format; write
// only while the block is idle.
// path: a payload byte goes from its req beat to the job register and then to
// the rsp output register; a byte that opens a packet follows its header.
// throughput: one req beat per cycle while no header is sent and rsp_stall
// is low; req_stall is high while the header is sent, set by the one-entry
// job register in front of the rsp output register.
// reset: counters and valid flags clear, csr registers return to their
// defaults (max_payload 50000, stream_format 19).
// rsp_stall holds the output register; the job register then fills and
// req_stall rises until the output register drains.
module video_unit_fragment_packetizer
   import vufp_pkg::*;
#(
   parameter int unsigned UNIT_LEN_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic [UNIT_LEN_BITS-1:0] req_unit_length,
   input  logic                     req_unit_first,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_is_header,
   output logic                     rsp_packet_last,
   output logic                     rsp_unit_last,
   input  logic                     csr_wr_en,
   input  logic                     csr_index,
   input  logic [31:0]              csr_wdata
);

   logic [15:0]              max_payload_ff;
   logic [31:0]              stream_format_ff;
   logic [31:0]              unit_counter_ff, unit_counter_in;
   logic [7:0]               packet_index_ff, packet_index_in;
   logic [UNIT_LEN_BITS-1:0] unit_left_ff, unit_left_in;
   logic [15:0]              packet_left_ff, packet_left_in;

   logic                     job_valid_ff, job_valid_in;
   job_type                  job_ff, job_in;
   logic [HDR_CNT_BITS-1:0]  hdr_cnt_ff, hdr_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff, rsp_byte_in;
   logic                     rsp_hdr_ff, rsp_hdr_in;
   logic                     rsp_plast_ff, rsp_plast_in;
   logic                     rsp_ulast_ff, rsp_ulast_in;

   logic                     req_accept;
   logic                     out_load;
   logic                     hdr_beat;
   logic                     job_done;
   logic                     item_live;
   logic [UNIT_LEN_BITS-1:0] len_eff;
   logic [UNIT_LEN_BITS-1:0] unit_left_eff;
   logic [15:0]              packet_left_eff;
   logic [7:0]               packet_index_eff;
   logic [15:0]              mp_eff;
   logic                     fits;
   logic [15:0]              size;
   logic                     opens;
   logic [15:0]              packet_left_new;
   logic [7:0]               hdr_byte;

   // output side
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign hdr_beat = job_ff.open && (hdr_cnt_ff != HDR_POS_DONE);
   assign job_done = job_valid_ff && out_load && !hdr_beat;

   assign req_stall  = job_valid_ff && !job_done;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      case (hdr_cnt_ff)
         HDR_POS_MARK:  hdr_byte = job_ff.mark_last ? MARK_LAST : MARK_MORE;
         HDR_POS_INDEX: hdr_byte = packet_index_ff;
         HDR_POS_SEQ0:  hdr_byte = unit_counter_ff[7:0];
         HDR_POS_SEQ1:  hdr_byte = unit_counter_ff[15:8];
         HDR_POS_SEQ2:  hdr_byte = unit_counter_ff[23:16];
         HDR_POS_SEQ3:  hdr_byte = unit_counter_ff[31:24];
         HDR_POS_FMT0:  hdr_byte = stream_format_ff[7:0];
         HDR_POS_FMT1:  hdr_byte = stream_format_ff[15:8];
         HDR_POS_FMT2:  hdr_byte = stream_format_ff[23:16];
         HDR_POS_FMT3:  hdr_byte = stream_format_ff[31:24];
         default:       hdr_byte = MARK_MORE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_hdr_in   = rsp_hdr_ff;
      rsp_plast_in = rsp_plast_ff;
      rsp_ulast_in = rsp_ulast_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      if (out_load) begin
         rsp_valid_in = job_valid_ff;
         if (job_valid_ff && hdr_beat) begin
            rsp_byte_in  = hdr_byte;
            rsp_hdr_in   = 1'b1;
            rsp_plast_in = 1'b0;
            rsp_ulast_in = 1'b0;
            hdr_cnt_in   = hdr_cnt_ff + HDR_CNT_BITS'(1);
         end else begin
            rsp_byte_in  = job_ff.data;
            rsp_hdr_in   = 1'b0;
            rsp_plast_in = job_ff.packet_last;
            rsp_ulast_in = job_ff.unit_last;
            hdr_cnt_in   = HDR_POS_MARK;
         end
      end
   end

   // input side: state update at accept
   always_comb begin
      len_eff          = (req_unit_length == '0) ? UNIT_LEN_BITS'(1) : req_unit_length;
      unit_left_eff    = req_unit_first ? len_eff : unit_left_ff;
      packet_left_eff  = req_unit_first ? 16'd0 : packet_left_ff;
      packet_index_eff = req_unit_first ? 8'd0 : packet_index_ff;
      item_live        = req_unit_first || (unit_left_ff != '0);
      mp_eff           = (max_payload_ff == 16'd0) ? 16'd1 : max_payload_ff;
      fits             = UNIT_LEN_BITS'(mp_eff) >= unit_left_eff;
      size             = fits ? unit_left_eff[15:0] : mp_eff;
      opens            = (packet_left_eff == 16'd0);
      packet_left_new  = opens ? size : packet_left_eff;

      unit_counter_in  = unit_counter_ff;
      packet_index_in  = packet_index_ff;
      unit_left_in     = unit_left_ff;
      packet_left_in   = packet_left_ff;
      job_valid_in     = job_done ? 1'b0 : job_valid_ff;
      job_in           = job_ff;

      if (req_accept && item_live) begin
         unit_counter_in = req_unit_first ? unit_counter_ff + 32'd1 : unit_counter_ff;
         packet_index_in = opens ? packet_index_eff + 8'd1 : packet_index_eff;
         unit_left_in    = unit_left_eff - UNIT_LEN_BITS'(1);
         packet_left_in  = packet_left_new - 16'd1;
         job_valid_in    = 1'b1;
         job_in.data        = req_data_byte;
         job_in.open        = opens;
         job_in.mark_last   = fits;
         job_in.packet_last = (packet_left_new == 16'd1);
         job_in.unit_last   = (unit_left_eff == UNIT_LEN_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff   <= MAX_PAYLOAD_RESET;
         stream_format_ff <= STREAM_FORMAT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD:   max_payload_ff   <= csr_wdata[15:0];
            CSR_STREAM_FORMAT: stream_format_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_counter_ff <= '0;
         packet_index_ff <= '0;
         unit_left_ff    <= '0;
         packet_left_ff  <= '0;
         job_valid_ff    <= 1'b0;
         hdr_cnt_ff      <= HDR_POS_MARK;
         rsp_valid_ff    <= 1'b0;
      end else begin
         unit_counter_ff <= unit_counter_in;
         packet_index_ff <= packet_index_in;
         unit_left_ff    <= unit_left_in;
         packet_left_ff  <= packet_left_in;
         job_valid_ff    <= job_valid_in;
         hdr_cnt_ff      <= hdr_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_hdr_ff   <= rsp_hdr_in;
      rsp_plast_ff <= rsp_plast_in;
      rsp_ulast_ff <= rsp_ulast_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_is_header   = rsp_hdr_ff;
   assign rsp_packet_last = rsp_plast_ff;
   assign rsp_unit_last   = rsp_ulast_ff;

endmodule

>>> sim/video_unit_fragment_packetizer_test.sv
`timescale 1ns / 100ps

module video_unit_fragment_packetizer_test;
   import vufp_pkg::*;

   localparam int LEN_BITS = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD = 250;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic       packet_last;
      logic       unit_last;
   } wire_byte_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_data_byte;
   logic [LEN_BITS-1:0] req_unit_length;
   logic                req_unit_first;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [7:0]          rsp_out_byte;
   logic                rsp_is_header;
   logic                rsp_packet_last;
   logic                rsp_unit_last;
   logic                csr_wr_en;
   logic                csr_index;
   logic [31:0]         csr_wdata;

   // packetizer state as predicted from the accepted beats
   logic [15:0]         cfg_max_payload;
   logic [31:0]         cfg_stream_format;
   logic [31:0]         unit_seq;
   logic [7:0]          pkt_index;
   logic [LEN_BITS-1:0] unit_left;
   logic [15:0]         pkt_left;

   wire_byte_type       expected_wire[$];
   int                  wire_errors;
   int                  bytes_taken;
   int                  cycle_count;
   int                  idle_pct;
   int                  stall_pct;
   int                  hold_left;

   video_unit_fragment_packetizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_unit_length (req_unit_length),
      .req_unit_first  (req_unit_first),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_header   (rsp_is_header),
      .rsp_packet_last (rsp_packet_last),
      .rsp_unit_last   (rsp_unit_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic report(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      wire_errors++;
   endtask

   task automatic push_wire(input logic [7:0] b, input logic hdr, input logic pl,
                            input logic ul);
      wire_byte_type w;
      w.out_byte = b;
      w.is_header = hdr;
      w.packet_last = pl;
      w.unit_last = ul;
      expected_wire.push_back(w);
   endtask

   task automatic predict_wire_bytes(input logic [7:0] data,
                                     input logic [LEN_BITS-1:0] len,
                                     input logic first);
      logic [16:0]         eff_max;
      logic [LEN_BITS-1:0] pkt_size;
      logic [7:0]          mark;
      if (first) begin
         unit_seq = unit_seq + 32'd1;
         pkt_index = 8'd0;
         unit_left = (len == '0) ? LEN_BITS'(1) : len;
         pkt_left = 16'd0;
      end else if (unit_left == '0) begin
         return;
      end
      bytes_taken++;
      if (pkt_left == 16'd0) begin
         eff_max = (cfg_max_payload == 16'd0) ? 17'd1 : {1'b0, cfg_max_payload};
         pkt_size = (unit_left < LEN_BITS'(eff_max)) ? unit_left : LEN_BITS'(eff_max);
         mark = (pkt_size == unit_left) ? MARK_LAST : MARK_MORE;
         pkt_index = pkt_index + 8'd1;
         push_wire(mark, 1'b1, 1'b0, 1'b0);
         push_wire(pkt_index, 1'b1, 1'b0, 1'b0);
         for (int i = 0; i < 4; i++) begin
            push_wire(unit_seq[8*i +: 8], 1'b1, 1'b0, 1'b0);
         end
         for (int i = 0; i < 4; i++) begin
            push_wire(cfg_stream_format[8*i +: 8], 1'b1, 1'b0, 1'b0);
         end
         pkt_left = pkt_size[15:0];
      end
      push_wire(data, 1'b0, pkt_left == 16'd1, unit_left == LEN_BITS'(1));
      pkt_left = pkt_left - 16'd1;
      unit_left = unit_left - LEN_BITS'(1);
   endtask

   always @(posedge clock) begin
      wire_byte_type exp_w;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_wire_bytes(req_data_byte, req_unit_length, req_unit_first);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_wire.size() == 0) begin
               report($sformatf("unexpected beat %02h", rsp_out_byte));
            end else begin
               exp_w = expected_wire.pop_front();
               if (rsp_out_byte !== exp_w.out_byte)
                  report($sformatf("out_byte %02h, want %02h", rsp_out_byte, exp_w.out_byte));
               if (rsp_is_header !== exp_w.is_header)
                  report($sformatf("is_header %b, want %b", rsp_is_header, exp_w.is_header));
               if (rsp_packet_last !== exp_w.packet_last)
                  report($sformatf("packet_last %b, want %b", rsp_packet_last,
                                   exp_w.packet_last));
               if (rsp_unit_last !== exp_w.unit_last)
                  report($sformatf("unit_last %b, want %b", rsp_unit_last, exp_w.unit_last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // receiver side: long hold-off when requested, random stalls otherwise
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic [LEN_BITS-1:0] len,
                            input logic first);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_unit_length <= len;
      req_unit_first <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_unit(input logic [LEN_BITS-1:0] len, input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(8'($urandom_range(255)),
                   (i == 0) ? len : LEN_BITS'($urandom_range(20'hFFFFF)), i == 0);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_wire.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      drain;
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_MAX_PAYLOAD)
         cfg_max_payload = value[15:0];
      else
         cfg_stream_format = value;
   endtask

   task automatic test_reset_defaults;
      send_byte(8'h00, 20'd3, 1'b1);
      send_byte(8'hFF, 20'hFFFFF, 1'b0);
      send_byte(8'hA5, 20'd0, 1'b0);
   endtask

   task automatic test_stray_and_zero_length;
      // no unit open: ignored
      send_byte(8'h5A, 20'hFFFFF, 1'b0);
      send_byte(8'h3C, 20'd0, 1'b1);
      send_byte(8'h11, 20'd7, 1'b0);
   endtask

   task automatic test_abandoned_unit;
      send_byte(8'h81, 20'hFFFFF, 1'b1);
      send_byte(8'h7E, 20'h55555, 1'b0);
      send_byte(8'h42, 20'hAAAAA, 1'b0);
      send_unit(20'd2, 2);
   endtask

   task automatic test_config_extremes;
      write_csr(CSR_MAX_PAYLOAD, 32'd0);
      write_csr(CSR_STREAM_FORMAT, 32'hFFFF_FFFF);
      send_unit(20'd3, 3);
      write_csr(CSR_MAX_PAYLOAD, 32'd65535);
      write_csr(CSR_STREAM_FORMAT, 32'd0);
      send_unit(20'd2, 2);
   endtask

   task automatic test_full_last_packet;
      write_csr(CSR_MAX_PAYLOAD, 32'd3);
      write_csr(CSR_STREAM_FORMAT, 32'h1234_5678);
      send_unit(20'd6, 6);
      send_unit(20'd4, 4);
   endtask

   task automatic test_packet_index_wrap;
      write_csr(CSR_MAX_PAYLOAD, 32'd1);
      send_unit(20'd258, 258);
   endtask

   task automatic test_backpressure;
      write_csr(CSR_MAX_PAYLOAD, 32'd8);
      idle_pct = 0;
      stall_pct = 0;
      hold_left = LONG_HOLD;
      send_unit(20'd16, 16);
      drain;
   endtask

   task automatic test_random_units(input int sender_idle, input int receiver_stall,
                                    input int target);
      int start;
      int pick;
      int len;
      case ($urandom_range(3))
         0: write_csr(CSR_MAX_PAYLOAD, $urandom_range(1, 4));
         1: write_csr(CSR_MAX_PAYLOAD, $urandom_range(5, 16));
         2: write_csr(CSR_MAX_PAYLOAD, $urandom_range(17, 64));
         default: write_csr(CSR_MAX_PAYLOAD, $urandom_range(65535));
      endcase
      write_csr(CSR_STREAM_FORMAT, $urandom);
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      start = bytes_taken;
      while (bytes_taken - start < target) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            len = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 24);
            send_unit(LEN_BITS'(len), (len == 0) ? 1 : len);
         end else if (pick < 92) begin
            // mostly cut short, the next first beat abandons it
            len = $urandom_range(2, 20'hFFFFF);
            send_unit(LEN_BITS'(len), $urandom_range(1, 6));
         end else begin
            repeat ($urandom_range(1, 3))
               send_byte(8'($urandom_range(255)), LEN_BITS'($urandom_range(20'hFFFFF)),
                         1'b0);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'd0;
      req_unit_length = '0;
      req_unit_first = 1'b0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = CSR_MAX_PAYLOAD;
      csr_wdata = 32'd0;
      cfg_max_payload = MAX_PAYLOAD_RESET;
      cfg_stream_format = STREAM_FORMAT_RESET;
      unit_seq = 32'd0;
      pkt_index = 8'd0;
      unit_left = '0;
      pkt_left = 16'd0;
      wire_errors = 0;
      bytes_taken = 0;
      cycle_count = 0;
      idle_pct = 25;
      stall_pct = 25;
      hold_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults;
      test_stray_and_zero_length;
      test_abandoned_unit;
      test_config_extremes;
      test_full_last_packet;
      test_packet_index_wrap;
      test_backpressure;
      test_random_units(0, 0, 5);
      test_random_units(52, 0, 5);
      test_random_units(0, 52, 5);
      test_random_units(30, 30, 5);

      drain;
      if (expected_wire.size() != 0)
         report($sformatf("%0d beats never arrived", expected_wire.size()));
      if (wire_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
